// ----- rtl/core/quaternion_to_euler_angles_defines.svh -----
// Assertion macros for the quaternion to Euler angle converter.
// Used by the top level; no dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define Q2E_ASSERT_AFTER(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define Q2E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define Q2E_ASSERT_AFTER(lbl, clk, ante, cons, msg)
`endif
`endif

// ----- rtl/core/q2e_pkg.sv -----
// Constants and the arctangent table for the quaternion to Euler converter.
// No dependencies.
`default_nettype none
package q2e_pkg;
  localparam int OPW = 34;  // width of atan2 operands
  localparam int DW  = 37;  // CORDIC x/y datapath width
  localparam int ZW  = 34;  // Q.30 angle accumulator width
  localparam int RW  = 18;  // rounded Q3.13 angle before saturation
  localparam int MAX_STAGES = 32;

  localparam logic signed [OPW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [RW-1:0]  PI_Q13      = 18'sd25736;
  localparam logic signed [RW-1:0]  HALF_PI_Q13 = 18'sd12868;

  localparam logic [30:0] ATAN_TAB [MAX_STAGES] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };
endpackage
`default_nettype wire

// ----- rtl/core/quaternion_to_euler_angles.sv -----
// Quaternion (Q1.15) to ZYX Euler angles (Q3.13 radians), fully pipelined.
// Depends on q2e_pkg, q2e_cordic and quaternion_to_euler_angles_defines.svh.
//
// Usage: drive quat_w/x/y/z and pulse start; a word is taken on every edge
// where start is high and busy is low. busy never rises, so a new quaternion
// may enter on every cycle. Each word comes back with done
// high for exactly one cycle, carrying roll_angle, pitch_angle, yaw_angle
// and pitch_clamped. Words leave in the order they came in.
// Pipeline: product, sum, square and subtract stages, 31 square-root stages
//   for the pitch cosine, one rotation stage plus one stage per CORDIC
//   iteration, rounding, and saturation into the output register.
// Throughput: one quaternion per cycle; set by the three parallel CORDIC
//   pipelines and the bit-per-stage square root.
// The receiver cannot stall: results must be taken in the done cycle.
// Reset clears every valid bit in the pipeline; words in flight are dropped.
// pitch_clamped marks a sine term outside [-1,1], held to +-1 (pitch +-pi/2).
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    done,
  output logic signed [15:0]      roll_angle,
  output logic signed [14:0]      pitch_angle,
  output logic signed [15:0]      yaw_angle,
  output logic                    pitch_clamped
);
  localparam int OPW = q2e_pkg::OPW;
  localparam int RW  = q2e_pkg::RW;
  localparam int CN  = (CORDIC_STAGES > q2e_pkg::MAX_STAGES) ? q2e_pkg::MAX_STAGES
                                                             : CORDIC_STAGES;
  localparam int CL  = CN + 2;  // clamp-flag delay matching the CORDIC module
  localparam int SQ  = 31;      // square-root stages

  assign busy = 1'b0;

  // products
  logic v1;
  logic signed [31:0] wx, yz, xx, yy, wz, xy, zz, wy, xz;
  always_ff @(posedge clk) begin
    wx <= quat_w * quat_x;
    yz <= quat_y * quat_z;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    wz <= quat_w * quat_z;
    xy <= quat_x * quat_y;
    zz <= quat_z * quat_z;
    wy <= quat_w * quat_y;
    xz <= quat_x * quat_z;
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
  end

  // sums and sine clamp
  logic signed [OPW-1:0] rn_next, rd_next, yn_next, yd_next, s_raw;
  always_comb begin
    rn_next = (OPW'(wx) + OPW'(yz)) <<< 1;
    rd_next = q2e_pkg::ONE_Q30 - ((OPW'(xx) + OPW'(yy)) <<< 1);
    yn_next = (OPW'(wz) + OPW'(xy)) <<< 1;
    yd_next = q2e_pkg::ONE_Q30 - ((OPW'(yy) + OPW'(zz)) <<< 1);
    s_raw   = (OPW'(wy) - OPW'(xz)) <<< 1;
  end

  logic v2, cl2;
  logic signed [OPW-1:0] rn2, rd2, yn2, yd2;
  logic signed [31:0] s2;
  always_ff @(posedge clk) begin
    rn2 <= rn_next;
    rd2 <= rd_next;
    yn2 <= yn_next;
    yd2 <= yd_next;
    if (s_raw > q2e_pkg::ONE_Q30) begin
      s2  <= 32'(q2e_pkg::ONE_Q30);
      cl2 <= 1'b1;
    end else if (s_raw < -q2e_pkg::ONE_Q30) begin
      s2  <= 32'(-q2e_pkg::ONE_Q30);
      cl2 <= 1'b1;
    end else begin
      s2  <= 32'(s_raw);
      cl2 <= 1'b0;
    end
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  // square of the sine
  logic v3, cl3;
  logic signed [OPW-1:0] rn3, rd3, yn3, yd3;
  logic signed [31:0] s3;
  logic signed [63:0] sq_full;
  logic [60:0] sq3;
  assign sq_full = s2 * s2;
  always_ff @(posedge clk) begin
    sq3 <= sq_full[60:0];
    s3  <= s2;
    cl3 <= cl2;
    rn3 <= rn2;
    rd3 <= rd2;
    yn3 <= yn2;
    yd3 <= yd2;
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end

  typedef struct packed {
    logic                  vld;
    logic                  cl;
    logic [60:0]           rem;
    logic [61:0]           res;
    logic signed [31:0]    s;
    logic signed [OPW-1:0] rn;
    logic signed [OPW-1:0] rd;
    logic signed [OPW-1:0] yn;
    logic signed [OPW-1:0] yd;
  } sq_t;

  sq_t sqs [SQ+1];

  always_ff @(posedge clk) begin
    sqs[0].cl  <= cl3;
    sqs[0].rem <= (61'(1) << 60) - sq3;
    sqs[0].res <= '0;
    sqs[0].s   <= s3;
    sqs[0].rn  <= rn3;
    sqs[0].rd  <= rd3;
    sqs[0].yn  <= yn3;
    sqs[0].yd  <= yd3;
    if (rst) sqs[0].vld <= 1'b0;
    else sqs[0].vld <= v3;
  end

  // one result bit per stage, test bit 4^(30-k)
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQ - 1 - k));
    sq_t sq_next;
    logic [61:0] trial;
    always_comb begin
      sq_next = sqs[k];
      trial   = sqs[k].res + BIT;
      if ({1'b0, sqs[k].rem} >= trial) begin
        sq_next.rem = sqs[k].rem - trial[60:0];
        sq_next.res = (sqs[k].res >> 1) + BIT;
      end else begin
        sq_next.res = sqs[k].res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sqs[k+1] <= '0;
      else sqs[k+1] <= sq_next;
    end
  end

  // three atan2 pipelines in lockstep
  logic                 vr, vp, vy;
  logic signed [RW-1:0] roll_r, pitch_r, yaw_r;
  logic signed [OPW-1:0] pitch_x, pitch_y;
  assign pitch_y = OPW'(sqs[SQ].s);
  assign pitch_x = OPW'({1'b0, sqs[SQ].res[30:0]});

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst(rst), .in_valid(sqs[SQ].vld),
    .in_x(sqs[SQ].rd), .in_y(sqs[SQ].rn),
    .out_valid(vr), .out_angle(roll_r)
  );
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst(rst), .in_valid(sqs[SQ].vld),
    .in_x(pitch_x), .in_y(pitch_y),
    .out_valid(vp), .out_angle(pitch_r)
  );
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .rst(rst), .in_valid(sqs[SQ].vld),
    .in_x(sqs[SQ].yd), .in_y(sqs[SQ].yn),
    .out_valid(vy), .out_angle(yaw_r)
  );

  // carry the clamp flag alongside the CORDIC
  logic cl_d [CL];
  always_ff @(posedge clk) cl_d[0] <= sqs[SQ].cl;
  for (genvar j = 1; j < CL; j++) begin : g_cl
    always_ff @(posedge clk) cl_d[j] <= cl_d[j-1];
  end

  // saturate into the output register
  logic signed [RW-1:0] roll_s, pitch_s, yaw_s;
  always_comb begin
    roll_s = roll_r;
    if (roll_r > q2e_pkg::PI_Q13) roll_s = q2e_pkg::PI_Q13;
    if (roll_r < -q2e_pkg::PI_Q13) roll_s = -q2e_pkg::PI_Q13;
    pitch_s = pitch_r;
    if (pitch_r > q2e_pkg::HALF_PI_Q13) pitch_s = q2e_pkg::HALF_PI_Q13;
    if (pitch_r < -q2e_pkg::HALF_PI_Q13) pitch_s = -q2e_pkg::HALF_PI_Q13;
    yaw_s = yaw_r;
    if (yaw_r > q2e_pkg::PI_Q13) yaw_s = q2e_pkg::PI_Q13;
    if (yaw_r < -q2e_pkg::PI_Q13) yaw_s = -q2e_pkg::PI_Q13;
  end

  always_ff @(posedge clk) begin
    roll_angle    <= roll_s[15:0];
    pitch_angle   <= pitch_s[14:0];
    yaw_angle     <= yaw_s[15:0];
    pitch_clamped <= cl_d[CL-1] && vp;
    if (rst) done <= 1'b0;
    else done <= vr && vp && vy;
  end

  `Q2E_ASSERT_AFTER(a_reset_quiet, clk, rst, !done, "strobe right after reset")
  `Q2E_ASSERT_NOW(a_flag_strobe, clk, rst, pitch_clamped, done, "clamp flag without strobe")
  `Q2E_ASSERT_NOW(a_pitch_range, clk, rst, done, (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868), "pitch out of range")
  `Q2E_ASSERT_NOW(a_roll_range, clk, rst, done, (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736), "roll out of range")
endmodule
`default_nettype wire

// ----- rtl/core/q2e_cordic.sv -----
// Pipelined vectoring CORDIC atan2 with Q3.13 rounding, one stage per iteration.
// Depends on q2e_pkg.
`default_nettype none
module q2e_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic signed [q2e_pkg::OPW-1:0]      in_x,
  input  wire logic signed [q2e_pkg::OPW-1:0]      in_y,
  output logic                                     out_valid,
  output logic signed [q2e_pkg::RW-1:0]            out_angle
);
  localparam int N = (STAGES > q2e_pkg::MAX_STAGES) ? q2e_pkg::MAX_STAGES : STAGES;
  localparam int DW = q2e_pkg::DW;
  localparam int ZW = q2e_pkg::ZW;

  logic signed [DW-1:0] xs [N+1];
  logic signed [DW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic                 zero [N+1];
  logic                 vs [N+1];

  logic signed [DW-1:0] xe, ye;
  assign xe = DW'(in_x);
  assign ye = DW'(in_y);

  // turn the vector into the right half plane first
  always_ff @(posedge clk) begin
    zero[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        xs[0] <= ye;
        ys[0] <= -xe;
        zs[0] <= q2e_pkg::HALF_PI_Q30;
      end else begin
        xs[0] <= -ye;
        ys[0] <= xe;
        zs[0] <= -q2e_pkg::HALF_PI_Q30;
      end
    end else begin
      xs[0] <= xe;
      ys[0] <= ye;
      zs[0] <= '0;
    end
    if (rst) vs[0] <= 1'b0;
    else vs[0] <= in_valid;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [ZW-1:0] ang;
    assign ang = ZW'({1'b0, q2e_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ang;
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ang;
      end
      zero[i+1] <= zero[i];
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
    end
  end

  // round half away from zero, Q.30 -> Q.13
  logic                 neg;
  logic [ZW-1:0]        mag;
  logic [ZW:0]          sum;
  logic signed [q2e_pkg::RW-1:0] rmag;
  assign neg  = zs[N][ZW-1];
  assign mag  = neg ? ZW'(-zs[N]) : ZW'(zs[N]);
  assign sum  = {1'b0, mag} + (ZW+1)'(65536);
  assign rmag = q2e_pkg::RW'(sum[ZW:17]);

  always_ff @(posedge clk) begin
    if (zero[N]) out_angle <= '0;
    else out_angle <= neg ? -rmag : rmag;
    if (rst) out_valid <= 1'b0;
    else out_valid <= vs[N];
  end
endmodule
`default_nettype wire
